// ----- sv/swrr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the sliding-window reorder receiver.
// Used by swrr_ctrl, swrr_datapath and sliding_window_reorder_receiver; depends on nothing.

package swrr_pkg;

    localparam int SEQ_W     = 32;
    localparam int LEN_W     = 11;
    localparam int HANDLE_W  = 16;
    localparam int CONN_W    = 16;
    localparam int CMD_W     = 2;
    localparam int WIN_REG_W = 5;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_ACK   = 2'd3;

    localparam logic KIND_DELIVER = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    localparam logic [WIN_REG_W-1:0] WIN_RESET = 5'd16;

    // What the held packet means for the connection.
    typedef enum logic [2:0] {
        CLS_NONE     = 3'd0,
        CLS_OPEN     = 3'd1,
        CLS_REACK    = 3'd2,
        CLS_CLOSE    = 3'd3,
        CLS_IN_ORDER = 3'd4,
        CLS_STORE    = 3'd5,
        CLS_OLD      = 3'd6
    } cls_t;

    typedef struct packed {
        logic load_item;
        logic capture;
        logic open;
        logic close;
        logic store;
        logic emit_item;
        logic emit_slot;
        logic emit_ack;
    } swrr_cmd_t;

    typedef struct packed {
        cls_t cls;
        logic slot_ready;
        logic out_free;
    } swrr_status_t;

endpackage

// ----- sv/swrr_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the sliding-window reorder receiver.
// Depends on swrr_pkg for the command and status structs.

module swrr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  swrr_pkg::swrr_status_t status,
    output swrr_pkg::swrr_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_EVAL    = 5'b00010,
        S_DELIVER = 5'b00100,
        S_DRAIN   = 5'b01000,
        S_ACK     = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.capture = 1'b1;
                case (status.cls) inside
                    swrr_pkg::CLS_OPEN:
                    begin
                        cmd.open   = 1'b1;
                        state_next = S_ACK;
                    end
                    swrr_pkg::CLS_CLOSE:
                    begin
                        cmd.close  = 1'b1;
                        state_next = S_ACK;
                    end
                    swrr_pkg::CLS_STORE:
                    begin
                        cmd.store  = 1'b1;
                        state_next = S_ACK;
                    end
                    swrr_pkg::CLS_REACK, swrr_pkg::CLS_OLD:
                    begin
                        state_next = S_ACK;
                    end
                    swrr_pkg::CLS_IN_ORDER:
                    begin
                        state_next = S_DELIVER;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DELIVER:
            begin
                if (status.out_free)
                begin
                    cmd.emit_item = 1'b1;
                    state_next    = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // Keep draining while the next expected slot holds a packet.
                if (status.slot_ready)
                begin
                    if (status.out_free)
                    begin
                        cmd.emit_slot = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_ACK;
                end
            end
            S_ACK:
            begin
                if (status.out_free)
                begin
                    cmd.emit_ack = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/swrr_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the sliding-window reorder receiver: held request, connection
// state, reorder slots and the output register. Depends on swrr_pkg.

module swrr_datapath
#(
    parameter int WINDOW      = 16,
    parameter int PAYLOAD_MAX = 2047
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [swrr_pkg::CMD_W-1:0]           command,
    input  logic [swrr_pkg::SEQ_W-1:0]           seq,
    input  logic [swrr_pkg::LEN_W-1:0]           length,
    input  logic                                 checksum_ok,
    input  logic [swrr_pkg::HANDLE_W-1:0]        payload_handle,
    input  logic                                 cfg_we,
    input  logic [swrr_pkg::WIN_REG_W-1:0]       cfg_wdata,
    input  swrr_pkg::swrr_cmd_t                  cmd,
    output swrr_pkg::swrr_status_t               status,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic                                 kind,
    output logic [swrr_pkg::SEQ_W-1:0]           out_seq,
    output logic [swrr_pkg::HANDLE_W-1:0]        out_handle,
    output logic [swrr_pkg::LEN_W-1:0]           out_length,
    output logic [swrr_pkg::CONN_W-1:0]          connection_index,
    output logic                                 last
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int EFF_W  = swrr_pkg::WIN_REG_W + 1;
    localparam int PMAX_W = 17;
    localparam int SEQ_W  = swrr_pkg::SEQ_W;

    localparam logic [EFF_W-1:0]  WIN_EFF_MAX = EFF_W'(WINDOW);
    localparam logic [IDX_W:0]    WIN_WIDE    = (IDX_W + 1)'(WINDOW);
    localparam logic [IDX_W-1:0]  IDX_LAST    = IDX_W'(WINDOW - 1);
    localparam logic [PMAX_W-1:0] LEN_LIMIT   = PMAX_W'(PAYLOAD_MAX);

    // Held request.
    logic [swrr_pkg::CMD_W-1:0]    item_cmd_reg;
    logic [SEQ_W-1:0]              item_seq_reg;
    logic [swrr_pkg::LEN_W-1:0]    item_len_reg;
    logic                          item_ok_reg;
    logic [swrr_pkg::HANDLE_W-1:0] item_handle_reg;

    // Connection state.
    logic [swrr_pkg::WIN_REG_W-1:0] window_reg;
    logic                           connected_reg;
    logic [SEQ_W-1:0]               start_reg;
    logic [SEQ_W-1:0]               exp_reg;
    logic [IDX_W-1:0]               exp_idx_reg;
    logic [swrr_pkg::CONN_W-1:0]    conn_count_reg;
    logic [swrr_pkg::CONN_W-1:0]    conn_idx_reg;
    logic                           ack_exp_reg;

    logic                          slot_valid_reg  [WINDOW];
    logic [swrr_pkg::HANDLE_W-1:0] slot_handle_reg [WINDOW];
    logic [swrr_pkg::LEN_W-1:0]    slot_len_reg    [WINDOW];

    // Output register.
    logic                          out_valid_reg;
    logic                          out_kind_reg;
    logic [SEQ_W-1:0]              out_seq_reg;
    logic [swrr_pkg::HANDLE_W-1:0] out_handle_reg;
    logic [swrr_pkg::LEN_W-1:0]    out_len_reg;
    logic [swrr_pkg::CONN_W-1:0]   out_conn_reg;
    logic                          out_last_reg;

    logic [EFF_W-1:0]  win_eff;
    logic [SEQ_W:0]    limit;
    logic              in_win;
    logic              bad;
    logic [SEQ_W-1:0]  diff;
    logic [IDX_W:0]    idx_sum;
    logic [IDX_W-1:0]  store_idx;
    logic [IDX_W-1:0]  exp_idx_inc;
    logic              out_free;
    logic              emit_any;
    swrr_pkg::cls_t    cls;

    // A window setting of zero acts as one; settings past the slot count clamp.
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = EFF_W'(1);
        end
        else if (EFF_W'(window_reg) > WIN_EFF_MAX)
        begin
            win_eff = WIN_EFF_MAX;
        end
        else
        begin
            win_eff = EFF_W'(window_reg);
        end
    end

    assign limit  = {1'b0, exp_reg} + (SEQ_W + 1)'(win_eff);
    assign in_win = {1'b0, item_seq_reg} < limit;
    assign bad    = ((item_len_reg != '0) && !item_ok_reg)
                    || (PMAX_W'(item_len_reg) > LEN_LIMIT);

    // A stored packet lies less than one window past the expected number, so
    // its slot follows from the expected slot plus the small offset.
    assign diff      = item_seq_reg - exp_reg;
    assign idx_sum   = {1'b0, exp_idx_reg} + {1'b0, diff[IDX_W-1:0]};
    assign store_idx = (idx_sum >= WIN_WIDE) ? IDX_W'(idx_sum - WIN_WIDE)
                                             : idx_sum[IDX_W-1:0];

    // The expected number wraps at 2^32, where its slot restarts at zero.
    always_comb
    begin
        if ((exp_reg == '1) || (exp_idx_reg == IDX_LAST))
        begin
            exp_idx_inc = '0;
        end
        else
        begin
            exp_idx_inc = exp_idx_reg + IDX_W'(1);
        end
    end

    always_comb
    begin
        cls = swrr_pkg::CLS_NONE;
        if (!connected_reg)
        begin
            if (item_cmd_reg == swrr_pkg::CMD_START)
            begin
                cls = swrr_pkg::CLS_OPEN;
            end
        end
        else if (!bad)
        begin
            unique case (item_cmd_reg)
                swrr_pkg::CMD_DATA:
                begin
                    if (in_win)
                    begin
                        if (item_seq_reg == exp_reg)
                        begin
                            cls = swrr_pkg::CLS_IN_ORDER;
                        end
                        else if (item_seq_reg > exp_reg)
                        begin
                            cls = swrr_pkg::CLS_STORE;
                        end
                        else
                        begin
                            cls = swrr_pkg::CLS_OLD;
                        end
                    end
                end
                swrr_pkg::CMD_END:
                begin
                    if (item_seq_reg == start_reg)
                    begin
                        cls = swrr_pkg::CLS_CLOSE;
                    end
                end
                swrr_pkg::CMD_START:
                begin
                    if (item_seq_reg == start_reg)
                    begin
                        cls = swrr_pkg::CLS_REACK;
                    end
                end
                swrr_pkg::CMD_ACK:
                begin
                    cls = swrr_pkg::CLS_NONE;
                end
                default:
                begin
                    cls = swrr_pkg::CLS_NONE;
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign emit_any = cmd.emit_item || cmd.emit_slot || cmd.emit_ack;

    assign status.cls        = cls;
    assign status.slot_ready = slot_valid_reg[exp_idx_reg];
    assign status.out_free   = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= swrr_pkg::WIN_RESET;
            connected_reg  <= 1'b0;
            start_reg      <= '0;
            exp_reg        <= '0;
            exp_idx_reg    <= '0;
            conn_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < WINDOW; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (cmd.open)
            begin
                connected_reg <= 1'b1;
                start_reg     <= item_seq_reg;
                exp_reg       <= '0;
                exp_idx_reg   <= '0;
                for (int i = 0; i < WINDOW; i++)
                begin
                    slot_valid_reg[i] <= 1'b0;
                end
            end
            if (cmd.close)
            begin
                connected_reg  <= 1'b0;
                conn_count_reg <= conn_count_reg + swrr_pkg::CONN_W'(1);
            end
            if (cmd.store)
            begin
                slot_valid_reg[store_idx] <= 1'b1;
            end
            if (cmd.emit_slot)
            begin
                slot_valid_reg[exp_idx_reg] <= 1'b0;
            end
            if (cmd.emit_item || cmd.emit_slot)
            begin
                exp_reg     <= exp_reg + SEQ_W'(1);
                exp_idx_reg <= exp_idx_inc;
            end
            if (emit_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_cmd_reg    <= command;
            item_seq_reg    <= seq;
            item_len_reg    <= length;
            item_ok_reg     <= checksum_ok;
            item_handle_reg <= payload_handle;
        end
        if (cmd.capture)
        begin
            conn_idx_reg <= conn_count_reg;
            ack_exp_reg  <= (cls == swrr_pkg::CLS_IN_ORDER) || (cls == swrr_pkg::CLS_STORE)
                            || (cls == swrr_pkg::CLS_OLD);
        end
        if (cmd.store)
        begin
            slot_handle_reg[store_idx] <= item_handle_reg;
            slot_len_reg[store_idx]    <= item_len_reg;
        end
        if (cmd.emit_item)
        begin
            out_kind_reg   <= swrr_pkg::KIND_DELIVER;
            out_seq_reg    <= item_seq_reg;
            out_handle_reg <= item_handle_reg;
            out_len_reg    <= item_len_reg;
            out_conn_reg   <= conn_idx_reg;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.emit_slot)
        begin
            out_kind_reg   <= swrr_pkg::KIND_DELIVER;
            out_seq_reg    <= exp_reg;
            out_handle_reg <= slot_handle_reg[exp_idx_reg];
            out_len_reg    <= slot_len_reg[exp_idx_reg];
            out_conn_reg   <= conn_idx_reg;
            out_last_reg   <= 1'b0;
        end
        else if (cmd.emit_ack)
        begin
            out_kind_reg   <= swrr_pkg::KIND_ACK;
            out_seq_reg    <= ack_exp_reg ? exp_reg : start_reg;
            out_handle_reg <= '0;
            out_len_reg    <= '0;
            out_conn_reg   <= conn_idx_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = out_kind_reg;
    assign out_seq          = out_seq_reg;
    assign out_handle       = out_handle_reg;
    assign out_length       = out_len_reg;
    assign connection_index = out_conn_reg;
    assign last             = out_last_reg;

    a_emit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_item, cmd.emit_slot, cmd.emit_ack}))
        else $error("more than one result loaded in one cycle");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_any |-> out_free)
        else $error("result loaded over an untaken result");

    a_drain_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_slot |-> slot_valid_reg[exp_idx_reg])
        else $error("drained an empty slot");

    a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_slot |=> !slot_valid_reg[$past(exp_idx_reg)])
        else $error("drained slot still marked valid");

    a_store_connected: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> connected_reg && ({1'b0, idx_sum} < {WIN_WIDE, 1'b0}))
        else $error("slot stored outside a connection");

endmodule

// ----- sv/sliding_window_reorder_receiver.sv -----
`timescale 1ns / 1ps
// Top level of the sliding-window reorder receiver.
// Instantiates swrr_ctrl and swrr_datapath; depends on swrr_pkg.

// Usage:
// The input channel (in_valid / in_stall) takes one packet descriptor per
// request. The output channel (out_valid / out_stall) gives the results that
// the descriptor causes, one per request, with last set on the final one:
// in-order deliveries first, then the cumulative or connection ACK.
// The window register is written through cfg_we / cfg_wdata; the user must
// write it only while the block is idle, as the block does not enforce this.
// A descriptor is taken in one cycle and examined in the next. A dropped
// descriptor then returns the block to idle; one that gives only an ACK goes
// on to the ACK state. An in-order DATA is delivered first, then the buffered
// slots drain, one result per cycle while the output side does not stall.
// The controller handles one descriptor at a time, so in_stall stays high
// from acceptance until its final result is loaded into the output register.
// A stall on the output side holds that register and stops the drain.
// Reset returns the block to idle with no connection, the window at 16 and
// the connection count at zero; it takes effect at once.

module sliding_window_reorder_receiver
#(
    parameter int WINDOW      = 16,
    parameter int PAYLOAD_MAX = 2047
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [swrr_pkg::CMD_W-1:0]     command,
    input  logic [swrr_pkg::SEQ_W-1:0]     seq,
    input  logic [swrr_pkg::LEN_W-1:0]     length,
    input  logic                           checksum_ok,
    input  logic [swrr_pkg::HANDLE_W-1:0]  payload_handle,
    input  logic                           cfg_we,
    input  logic [swrr_pkg::WIN_REG_W-1:0] cfg_wdata,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           kind,
    output logic [swrr_pkg::SEQ_W-1:0]     out_seq,
    output logic [swrr_pkg::HANDLE_W-1:0]  out_handle,
    output logic [swrr_pkg::LEN_W-1:0]     out_length,
    output logic [swrr_pkg::CONN_W-1:0]    connection_index,
    output logic                           last
);

    swrr_pkg::swrr_cmd_t    cmd;
    swrr_pkg::swrr_status_t status;

    swrr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    swrr_datapath
    #(
        .WINDOW      (WINDOW),
        .PAYLOAD_MAX (PAYLOAD_MAX)
    )
    u_datapath
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .command          (command),
        .seq              (seq),
        .length           (length),
        .checksum_ok      (checksum_ok),
        .payload_handle   (payload_handle),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd),
        .status           (status),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .kind             (kind),
        .out_seq          (out_seq),
        .out_handle       (out_handle),
        .out_length       (out_length),
        .connection_index (connection_index),
        .last             (last)
    );

endmodule
